// ----- src/radio_frame_deframer_macros.svh -----
// Assertion macros for the radio frame deframer modules; only rfd_queue uses them.
`ifndef RADIO_FRAME_DEFRAMER_MACROS_SVH
`define RADIO_FRAME_DEFRAMER_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define RFD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define RFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rfd_pkg.sv -----
// Types and constants shared by the radio frame deframer modules.
package rfd_pkg;

    typedef enum logic [2:0] {
        KIND_PAYLOAD    = 3'd0,
        KIND_FRAME_GOOD = 3'd1,
        KIND_FRAME_BAD  = 3'd2,
        KIND_SHORT      = 3'd3,
        KIND_HDR_REJECT = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         data_byte;
        logic [28:0]        message_id;
        logic               burst;
        logic signed [7:0]  rssi;
        logic [6:0]         link_quality;
        logic [6:0]         payload_length;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    localparam logic [7:0] HDR_OVERHEAD = 8'd5;
    localparam logic [7:0] ID_LAST_IDX  = 8'd3;
    localparam int         CRC_OK_BIT   = 7;
    localparam int         BURST_BIT    = 31;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_BITS    = 60;
    localparam int OUT_TUSER_W = 3;

endpackage

// ----- src/radio_frame_deframer.sv -----
// Top level of the radio frame deframer.
//
// The slave stream takes one received radio byte per word in s_axis_tdata, with
// s_axis_tlast set on the last byte of each receive burst. The master stream
// gives one result word per payload byte, per finished frame, per short length
// and per rejected header; the result kind travels in m_axis_tuser.
// The own address is written through the cfg channel; the user must do so only
// while the block is idle, which the block itself does not enforce. A byte that
// yields a result passes through the queue and the output register before it
// shows on the master side. One byte is accepted every cycle while the queue is
// not full: the header parser updates its state once per byte, and a four-entry
// result queue plus the output register decouple it from the receiver.
// When the receiver stalls, results collect in the queue; once it is full,
// s_axis_tready drops until the receiver takes a word.
// Reset clears the parser state, the own address and the queue, and the
// parser then expects a length byte.
module radio_frame_deframer #(
    parameter int MAX_LENGTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Fields from bit 0: rx_byte[7:0].
    input  logic [rfd_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Fields from bit 0: data_byte[7:0], message_id[36:8], burst[37],
    // rssi[45:38], link_quality[52:46], payload_length[59:53], zeros above.
    output logic [rfd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // Fields from bit 0: kind[2:0].
    output logic [rfd_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser
);
    import rfd_pkg::*;

    t_push     push;
    t_q_status q_status;
    t_result   head;
    logic      pop;

    assign o_cfg_ready = 1'b1;

    rfd_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .i_byte      (i_s_axis_tdata[7:0]),
        .i_last      (i_s_axis_tlast),
        .i_q_status  (q_status),
        .o_ready     (o_s_axis_tready),
        .o_push      (push)
    );

    rfd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_status (q_status),
        .o_head   (head)
    );

    rfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (head),
        .o_pop      (pop),
        .o_tvalid   (o_m_axis_tvalid),
        .i_tready   (i_m_axis_tready),
        .o_tdata    (o_m_axis_tdata),
        .o_tuser    (o_m_axis_tuser)
    );

endmodule

// ----- src/rfd_queue.sv -----
// Short result queue between the header parser and the output stage.
`include "radio_frame_deframer_macros.svh"

module rfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rfd_pkg::t_push  i_push,
    input  logic            i_pop,
    output rfd_pkg::t_q_status o_status,
    output rfd_pkg::t_result   o_head
);
    import rfd_pkg::*;

    t_result               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]    r_wr_ptr;
    logic [Q_PTR_W-1:0]    r_rd_ptr;
    logic [Q_CNT_W-1:0]    r_count;
    logic [Q_CNT_W-1:0]    n_count;

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.res;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    `RFD_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= Q_CNT_W'(Q_DEPTH), "queue count overflow")
    `RFD_ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, o_status.full, !i_push.valid, "push into full queue")
    `RFD_ASSERT_IMPLIES(a_no_pop_empty, i_clk, i_rst_n, o_status.empty, !i_pop, "pop from empty queue")
    `RFD_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push.valid && !i_pop, r_count == $past(r_count) + 1'b1, "queue count did not grow")

endmodule

// ----- src/rfd_front.sv -----
// Front end: accepts received bytes, tracks the frame layout and produces results.
module rfd_front #(
    parameter int MAX_LENGTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    input  rfd_pkg::t_q_status i_q_status,
    output logic               o_ready,
    output rfd_pkg::t_push     o_push
);
    import rfd_pkg::*;

    typedef enum logic [6:0] {
        ST_LEN     = 7'b0000001,
        ST_ADDR    = 7'b0000010,
        ST_DISCARD = 7'b0000100,
        ST_ID      = 7'b0001000,
        ST_PAY     = 7'b0010000,
        ST_ST1     = 7'b0100000,
        ST_ST2     = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_own_addr;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_cnt, n_cnt;
    logic [31:0] r_id, n_id;
    logic [7:0]  r_st1, n_st1;

    logic        accept;
    logic        len_too_long;
    logic        addr_bad;
    logic [7:0]  pay_len;
    logic [7:0]  cnt_inc;

    assign o_ready      = !i_q_status.full;
    assign accept       = i_valid && o_ready;
    assign len_too_long = {1'b0, r_len} >= 9'(MAX_LENGTH);
    assign addr_bad     = (i_byte != 8'd0) && (i_byte != r_own_addr);
    assign pay_len      = r_len - HDR_OVERHEAD;
    assign cnt_inc      = r_cnt + 8'd1;

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_id    = r_id;
        n_st1   = r_st1;
        o_push  = '0;
        if (accept) begin
            unique case (r_state)
                ST_LEN: begin
                    n_len   = i_byte;
                    n_state = ST_ADDR;
                end
                ST_ADDR: begin
                    if (len_too_long || addr_bad) begin
                        o_push.valid    = 1'b1;
                        o_push.res.kind = KIND_HDR_REJECT;
                        n_state         = i_last ? ST_LEN : ST_DISCARD;
                    end else if (r_len == 8'd0) begin
                        n_state = ST_LEN;
                    end else if (r_len < HDR_OVERHEAD) begin
                        o_push.valid    = 1'b1;
                        o_push.res.kind = KIND_SHORT;
                        n_state         = ST_LEN;
                    end else begin
                        n_cnt   = '0;
                        n_id    = '0;
                        n_state = ST_ID;
                    end
                end
                ST_DISCARD: begin
                    if (i_last) begin
                        n_state = ST_LEN;
                    end
                end
                ST_ID: begin
                    n_id  = {i_byte, r_id[31:8]};
                    n_cnt = cnt_inc;
                    if (r_cnt == ID_LAST_IDX) begin
                        n_cnt   = '0;
                        n_state = (r_len == HDR_OVERHEAD) ? ST_ST1 : ST_PAY;
                    end
                end
                ST_PAY: begin
                    n_cnt                = cnt_inc;
                    o_push.valid         = 1'b1;
                    o_push.res.kind      = KIND_PAYLOAD;
                    o_push.res.data_byte = i_byte;
                    if (cnt_inc >= pay_len) begin
                        n_state = ST_ST1;
                    end
                end
                ST_ST1: begin
                    n_st1   = i_byte;
                    n_state = ST_ST2;
                end
                ST_ST2: begin
                    o_push.valid              = 1'b1;
                    o_push.res.kind           = i_byte[CRC_OK_BIT] ? KIND_FRAME_GOOD
                                                                   : KIND_FRAME_BAD;
                    o_push.res.message_id     = r_id[28:0];
                    o_push.res.burst          = r_id[BURST_BIT];
                    o_push.res.rssi           = r_st1;
                    o_push.res.link_quality   = i_byte[6:0];
                    o_push.res.payload_length = pay_len[6:0];
                    n_state                   = ST_LEN;
                end
                default: begin
                    n_state = ST_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LEN;
            r_own_addr <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_own_addr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_cnt <= n_cnt;
        r_id  <= n_id;
        r_st1 <= n_st1;
    end

endmodule

// ----- src/rfd_back.sv -----
// Back end: takes results from the queue and holds them in the output register.
module rfd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfd_pkg::t_q_status i_q_status,
    input  rfd_pkg::t_result   i_head,
    output logic               o_pop,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [rfd_pkg::OUT_TDATA_W-1:0] o_tdata,
    output logic [rfd_pkg::OUT_TUSER_W-1:0] o_tuser
);
    import rfd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_pop = !i_q_status.empty && (!r_valid || i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = r_res.kind;
    assign o_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), r_res.payload_length,
                       r_res.link_quality, r_res.rssi, r_res.burst,
                       r_res.message_id, r_res.data_byte};

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the radio frame deframer with a predictor, stalls and drains.
module tb;
    import rfd_pkg::*;

    localparam int MAX_LEN     = 128;
    localparam int TAIL_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [2:0] {
        PARSE_LEN, PARSE_ADDR, PARSE_DISCARD, PARSE_ID,
        PARSE_PAYLOAD, PARSE_STATUS1, PARSE_STATUS2
    } t_parse;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_rx_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [7:0]             i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tlast = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;

    radio_frame_deframer #(.MAX_LENGTH(MAX_LEN)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    t_parse      parse_phase = PARSE_LEN;
    logic [7:0]  own_addr = '0;
    logic [7:0]  hdr_length = '0;
    logic [7:0]  byte_count = '0;
    logic [31:0] id_reg = '0;
    logic [7:0]  status_rssi = '0;

    t_result  expected_words[$];
    t_rx_word pending_bytes[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left = 0;
    int queued_bytes = 0;
    int sent_bytes = 0;
    int result_words = 0;
    int errors = 0;
    int kind_count[5] = '{default: 0};

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch in %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic last);
        t_result    r;
        logic [7:0] body_len;
        r = '0;
        body_len = hdr_length - HDR_OVERHEAD;
        case (parse_phase)
            PARSE_LEN: begin
                hdr_length  = b;
                parse_phase = PARSE_ADDR;
            end
            PARSE_ADDR: begin
                if (({1'b0, hdr_length} >= 9'(MAX_LEN)) ||
                    (b != 8'd0 && b != own_addr)) begin
                    parse_phase = last ? PARSE_LEN : PARSE_DISCARD;
                    r.kind = KIND_HDR_REJECT;
                    expected_words.push_back(r);
                end else if (hdr_length == 8'd0) begin
                    parse_phase = PARSE_LEN;
                end else if (hdr_length < HDR_OVERHEAD) begin
                    parse_phase = PARSE_LEN;
                    r.kind = KIND_SHORT;
                    expected_words.push_back(r);
                end else begin
                    byte_count  = '0;
                    id_reg      = '0;
                    parse_phase = PARSE_ID;
                end
            end
            PARSE_DISCARD: begin
                if (last) parse_phase = PARSE_LEN;
            end
            PARSE_ID: begin
                id_reg = {b, id_reg[31:8]};
                if (byte_count == ID_LAST_IDX) begin
                    byte_count  = '0;
                    parse_phase = (hdr_length == HDR_OVERHEAD) ? PARSE_STATUS1
                                                               : PARSE_PAYLOAD;
                end else begin
                    byte_count = byte_count + 8'd1;
                end
            end
            PARSE_PAYLOAD: begin
                byte_count = byte_count + 8'd1;
                if (byte_count >= body_len) parse_phase = PARSE_STATUS1;
                r.kind      = KIND_PAYLOAD;
                r.data_byte = b;
                expected_words.push_back(r);
            end
            PARSE_STATUS1: begin
                status_rssi = b;
                parse_phase = PARSE_STATUS2;
            end
            default: begin
                parse_phase      = PARSE_LEN;
                r.kind           = b[CRC_OK_BIT] ? KIND_FRAME_GOOD : KIND_FRAME_BAD;
                r.message_id     = id_reg[28:0];
                r.burst          = id_reg[BURST_BIT];
                r.rssi           = status_rssi;
                r.link_quality   = b[6:0];
                r.payload_length = body_len[6:0];
                expected_words.push_back(r);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_rx_word next_word;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                deframe_byte(i_s_axis_tdata, i_s_axis_tlast);
                sent_bytes++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = pending_bytes.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= next_word.value;
                    i_s_axis_tlast  <= next_word.last;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_ticket) begin
            hold_served <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            result_words++;
            if (expected_words.size() == 0) begin
                note_mismatch("unexpected word", o_m_axis_tdata, '0);
            end else begin
                want = expected_words.pop_front();
                if (want.kind <= KIND_HDR_REJECT) kind_count[want.kind]++;
                if (o_m_axis_tuser != want.kind)
                    note_mismatch("kind", 64'(o_m_axis_tuser), 64'(want.kind));
                if (o_m_axis_tdata[7:0] != want.data_byte)
                    note_mismatch("data_byte", 64'(o_m_axis_tdata[7:0]),
                                  64'(want.data_byte));
                if (o_m_axis_tdata[36:8] != want.message_id)
                    note_mismatch("message_id", 64'(o_m_axis_tdata[36:8]),
                                  64'(want.message_id));
                if (o_m_axis_tdata[37] != want.burst)
                    note_mismatch("burst", 64'(o_m_axis_tdata[37]), 64'(want.burst));
                if (o_m_axis_tdata[45:38] != want.rssi)
                    note_mismatch("rssi", 64'(o_m_axis_tdata[45:38]),
                                  64'($unsigned(want.rssi)));
                if (o_m_axis_tdata[52:46] != want.link_quality)
                    note_mismatch("link_quality", 64'(o_m_axis_tdata[52:46]),
                                  64'(want.link_quality));
                if (o_m_axis_tdata[59:53] != want.payload_length)
                    note_mismatch("payload_length", 64'(o_m_axis_tdata[59:53]),
                                  64'(want.payload_length));
                if (o_m_axis_tdata[63:60] != 4'd0)
                    note_mismatch("padding", 64'(o_m_axis_tdata[63:60]), '0);
            end
        end
    end

    function automatic logic rand_last();
        return $urandom_range(9) == 0;
    endfunction

    task automatic queue_byte(input logic [7:0] value, input logic last);
        t_rx_word w;
        w.value = value;
        w.last  = last;
        pending_bytes.push_back(w);
        queued_bytes++;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || i_s_axis_tvalid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_own_address(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        own_addr = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_traffic(input int n_bytes);
        int         stop;
        int         pick;
        int         len;
        int         j;
        logic [7:0] addr;
        stop = queued_bytes + n_bytes;
        while (queued_bytes < stop) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                len = ($urandom_range(24) == 0) ? $urandom_range(100, MAX_LEN - 1)
                                                : $urandom_range(5, 20);
                addr = ($urandom_range(1) == 0) ? 8'h00 : own_addr;
                queue_byte(len[7:0], rand_last());
                queue_byte(addr, rand_last());
                for (j = 0; j < len; j++) queue_byte(8'($urandom_range(255)), rand_last());
                queue_byte(8'($urandom_range(255)), $urandom_range(1) == 1);
            end else if (pick < 79) begin
                if (pick < 73) begin
                    len = $urandom_range(0, MAX_LEN - 1);
                    do addr = 8'($urandom_range(1, 255)); while (addr == own_addr);
                end else begin
                    len = $urandom_range(MAX_LEN, 255);
                    addr = 8'($urandom_range(255));
                end
                queue_byte(len[7:0], rand_last());
                queue_byte(addr, $urandom_range(4) == 0);
                repeat ($urandom_range(4)) queue_byte(8'($urandom_range(255)), 1'b0);
                queue_byte(8'($urandom_range(255)), 1'b1);
            end else if (pick < 85) begin
                queue_byte(8'($urandom_range(1, 4)), rand_last());
                queue_byte(($urandom_range(1) == 0) ? 8'h00 : own_addr, rand_last());
            end else if (pick < 90) begin
                queue_byte(8'h00, rand_last());
                queue_byte(($urandom_range(1) == 0) ? 8'h00 : own_addr, rand_last());
            end else begin
                repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(255)), rand_last());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 36;
        recv_idle_pct = 77;
        write_own_address(8'h5A);
        // Largest id with burst set, lowest rssi, good CRC, empty payload.
        queue_byte(8'h05, 1'b0); queue_byte(8'h00, 1'b0);
        repeat (4) queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0); queue_byte(8'hFF, 1'b1);
        // Own address, zero id, one payload byte with a stray chunk end, bad CRC.
        queue_byte(8'h06, 1'b0); queue_byte(8'h5A, 1'b0);
        repeat (4) queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1); queue_byte(8'h7F, 1'b0); queue_byte(8'h00, 1'b0);
        // Zero length, then a short length.
        queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
        queue_byte(8'h04, 1'b0); queue_byte(8'h00, 1'b0);
        // Too long, chunk end on the address byte.
        queue_byte(8'h80, 1'b0); queue_byte(8'h00, 1'b1);
        // Foreign address, discard up to the chunk end.
        queue_byte(8'h07, 1'b0); queue_byte(8'h33, 1'b0);
        queue_byte(8'h11, 1'b0); queue_byte(8'h22, 1'b1);
        wait_drained();

        write_own_address(8'h00);
        queue_traffic(210);
        wait_drained();
        queue_traffic(210);
        wait_drained();

        send_idle_pct = 77;
        recv_idle_pct = 36;
        write_own_address(8'hFF);
        queue_traffic(210);
        wait_drained();
        queue_traffic(210);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_own_address(8'($urandom_range(1, 254)));
        hold_ticket = hold_ticket + 1;
        queue_traffic(210);
        wait_drained();
        queue_traffic(210);
        wait_drained();

        if (expected_words.size() != 0)
            note_mismatch("words never produced", 64'(expected_words.size()), '0);
        $display("Fed %0d radio bytes across four own-address settings and stall mixes,",
                 sent_bytes);
        $display("%0d words back: payload %0d, good %0d, bad CRC %0d, short %0d, rejected %0d.",
                 result_words, kind_count[KIND_PAYLOAD], kind_count[KIND_FRAME_GOOD],
                 kind_count[KIND_FRAME_BAD], kind_count[KIND_SHORT],
                 kind_count[KIND_HDR_REJECT]);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
